// ===== sv/polar_joystick_differential_drive_assert.svh =====
// Assertion helpers used by the drive controller module pjdd_ctrl.
// In synthesis builds the macros expand to nothing.
`ifndef POLAR_JOYSTICK_DIFFERENTIAL_DRIVE_ASSERT_SVH
`define POLAR_JOYSTICK_DIFFERENTIAL_DRIVE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that expr holds at every clock edge out of reset.
`define PJDD_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that cons holds in the cycle after ante.
`define PJDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PJDD_ASSERT(lbl, clk, rst_n, expr)
`define PJDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/pjdd_pkg.sv =====
package pjdd_pkg;

    // Angle and trig table geometry
    localparam int ANGLE_STEPS    = 360;
    localparam int QUARTER_STEPS  = ANGLE_STEPS / 4;
    localparam int TRIG_FRAC_BITS = 16;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Field widths
    localparam int RADIUS_W  = 7;
    localparam int ANGLE_W   = 9;
    localparam int SPEED_W   = 8;
    localparam int IDLE_W    = 16;
    localparam int AXIS_W    = 8;   // signed x, y in -100..100
    localparam int MIX_MAG_W = 8;   // |y +- x| up to 200

    localparam logic [RADIUS_W-1:0] RADIUS_MAX = RADIUS_W'(100);
    localparam logic [SPEED_W-1:0]  SPEED_MAX  = '1;
    localparam logic [IDLE_W-1:0]   IDLE_MAX   = '1;

    // 255/100 as multiply by 167127 then shift by 16, exact for |v| <= 200
    localparam int MIX_RECIP   = 167127;
    localparam int MIX_SHIFT   = 16;
    localparam int MIX_RECIP_W = 18;
    localparam int MIX_PROD_W  = MIX_MAG_W + MIX_RECIP_W;
    localparam int MIX_Q_W     = MIX_PROD_W - MIX_SHIFT;

    // Configuration register indexes
    localparam logic REG_TIMEOUT  = 1'b0;
    localparam logic REG_OBSTACLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COS,
        S_SIN,
        S_MIX,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic calc_x;
        logic calc_y;
        logic mix;
        logic commit;
    } t_dp_cmd;

    typedef logic [TRIG_W-1:0] t_sin_quarter [0:QUARTER_STEPS];

    typedef struct packed {
        logic                     neg;
        logic [ANGLE_W-1:0]       base;
    } t_fold;

    // Quarter-wave sine table, rounded from a Q30 Taylor series
    function automatic t_sin_quarter build_sin_quarter();
        t_sin_quarter    rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int d = 0; d <= QUARTER_STEPS; d++) begin
            x    = (longint'(d) * 2 * PI_Q30 + ANGLE_STEPS / 2) / ANGLE_STEPS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            // alternate the odd-power terms; past the tenth they are zero in Q30
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd342;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd420;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum + (longint'(1) << (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
            rom[d] = TRIG_W'(v);
        end
        return rom;
    endfunction

    localparam t_sin_quarter SIN_QUARTER = build_sin_quarter();

    // Map an angle 0..359 onto the first quadrant and a sign
    function automatic t_fold fold_angle(input logic [ANGLE_W-1:0] a);
        t_fold f;
        if (a <= ANGLE_W'(QUARTER_STEPS)) begin
            f.neg  = 1'b0;
            f.base = a;
        end else if (a <= ANGLE_W'(2 * QUARTER_STEPS)) begin
            f.neg  = 1'b0;
            f.base = ANGLE_W'(2 * QUARTER_STEPS) - a;
        end else if (a <= ANGLE_W'(3 * QUARTER_STEPS)) begin
            f.neg  = 1'b1;
            f.base = a - ANGLE_W'(2 * QUARTER_STEPS);
        end else begin
            f.neg  = 1'b1;
            f.base = ANGLE_W'(ANGLE_STEPS) - a;
        end
        return f;
    endfunction

endpackage

// ===== sv/pjdd_ctrl.sv =====
`include "polar_joystick_differential_drive_assert.svh"

module pjdd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pjdd_pkg::t_dp_cmd o_cmd
);
    import pjdd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Hold state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequence one beat through capture, two products, mix and commit
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_COS;
                end
            end
            S_COS: begin
                o_cmd.calc_x = 1'b1;
                n_state      = S_SIN;
            end
            S_SIN: begin
                o_cmd.calc_y = 1'b1;
                n_state      = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `PJDD_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(o_cmd))
    `PJDD_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_COS)
    `PJDD_ASSERT_NEXT(a_commit_shows, i_clk, i_rst_n, o_cmd.commit, r_out_valid && r_state == S_IDLE)
    `PJDD_ASSERT_NEXT(a_done_holds, i_clk, i_rst_n, r_state == S_DONE && !out_free, r_state == S_DONE && r_out_valid)

endmodule

// ===== sv/pjdd_datapath.sv =====
module pjdd_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pjdd_pkg::t_dp_cmd                i_cmd,
    input  logic                             i_command_valid,
    input  logic [pjdd_pkg::RADIUS_W-1:0]    i_radius_percent,
    input  logic [pjdd_pkg::ANGLE_W-1:0]     i_angle_degrees,
    input  logic                             i_antenna_left,
    input  logic                             i_antenna_right,
    input  logic [pjdd_pkg::IDLE_W-1:0]      i_timeout_ticks,
    input  logic                             i_obstacle_enable,
    output logic [pjdd_pkg::SPEED_W-1:0]     o_left_speed_out,
    output logic [pjdd_pkg::SPEED_W-1:0]     o_right_speed_out,
    output logic                             o_left_reverse,
    output logic                             o_right_reverse
);
    import pjdd_pkg::*;

    // Captured beat
    logic                r_cmd;
    logic [RADIUS_W-1:0] r_radius;
    logic [ANGLE_W-1:0]  r_angle;
    logic                r_ant_l;
    logic                r_ant_r;

    // Products and mix results
    logic signed [AXIS_W-1:0] r_x;
    logic signed [AXIS_W-1:0] r_y;
    logic [SPEED_W-1:0]       r_mix_ls;
    logic [SPEED_W-1:0]       r_mix_rs;
    logic                     r_mix_ldir;
    logic                     r_mix_rdir;

    // Held drive state
    logic [SPEED_W-1:0] r_left_speed;
    logic [SPEED_W-1:0] r_right_speed;
    logic               r_left_dir;
    logic               r_right_dir;
    logic [IDLE_W-1:0]  r_idle;

    logic [SPEED_W-1:0] n_left_speed;
    logic [SPEED_W-1:0] n_right_speed;
    logic               n_left_dir;
    logic               n_right_dir;
    logic [IDLE_W-1:0]  n_idle;

    logic [ANGLE_W:0]                 cos_sum;
    logic [ANGLE_W-1:0]               cos_angle;
    t_fold                            fold;
    logic [TRIG_W-1:0]                trig_mag;
    logic [RADIUS_W+TRIG_W-1:0]       prod;
    logic [RADIUS_W-1:0]              prod_mag;
    logic signed [AXIS_W-1:0]         axis_val;

    logic signed [AXIS_W:0]           sum_lv;
    logic signed [AXIS_W:0]           sum_rv;
    logic [MIX_MAG_W-1:0]             mag_l;
    logic [MIX_MAG_W-1:0]             mag_r;
    logic [MIX_PROD_W-1:0]            scaled_l;
    logic [MIX_PROD_W-1:0]            scaled_r;
    logic [MIX_Q_W-1:0]               q_l;
    logic [MIX_Q_W-1:0]               q_r;
    logic [SPEED_W-1:0]               sat_l;
    logic [SPEED_W-1:0]               sat_r;
    logic                             dir_l;
    logic                             dir_r;
    logic [SPEED_W-1:0]               mix_ls;
    logic [SPEED_W-1:0]               mix_rs;

    // Pick the cosine or sine angle for the shared product
    always_comb begin
        cos_sum = {1'b0, r_angle} + (ANGLE_W+1)'(QUARTER_STEPS);
        if (cos_sum >= (ANGLE_W+1)'(ANGLE_STEPS)) begin
            cos_sum = cos_sum - (ANGLE_W+1)'(ANGLE_STEPS);
        end
        cos_angle = cos_sum[ANGLE_W-1:0];
        fold      = fold_angle(i_cmd.calc_x ? cos_angle : r_angle);
        trig_mag  = SIN_QUARTER[fold.base[6:0]];
        prod      = r_radius * trig_mag;
        prod_mag  = prod[TRIG_FRAC_BITS +: RADIUS_W];
        if (fold.neg) begin
            axis_val = -$signed({1'b0, prod_mag});
        end else begin
            axis_val = $signed({1'b0, prod_mag});
        end
    end

    // Mix x and y into two sides, scale by 255/100 and clamp
    always_comb begin
        sum_lv   = (AXIS_W+1)'(r_y) + (AXIS_W+1)'(r_x);
        sum_rv   = (AXIS_W+1)'(r_y) - (AXIS_W+1)'(r_x);
        mag_l    = sum_lv[AXIS_W] ? MIX_MAG_W'(-sum_lv) : MIX_MAG_W'(sum_lv);
        mag_r    = sum_rv[AXIS_W] ? MIX_MAG_W'(-sum_rv) : MIX_MAG_W'(sum_rv);
        scaled_l = mag_l * MIX_RECIP_W'(MIX_RECIP);
        scaled_r = mag_r * MIX_RECIP_W'(MIX_RECIP);
        q_l      = scaled_l[MIX_PROD_W-1:MIX_SHIFT];
        q_r      = scaled_r[MIX_PROD_W-1:MIX_SHIFT];
        sat_l    = (q_l > MIX_Q_W'(SPEED_MAX)) ? SPEED_MAX : q_l[SPEED_W-1:0];
        sat_r    = (q_r > MIX_Q_W'(SPEED_MAX)) ? SPEED_MAX : q_r[SPEED_W-1:0];
        dir_l    = !(sum_lv > 0);
        dir_r    = !(sum_rv > 0);
        // swap speeds when driving backward
        if (r_y < 0) begin
            mix_ls = sat_r;
            mix_rs = sat_l;
        end else begin
            mix_ls = sat_l;
            mix_rs = sat_r;
        end
        // pivot: stop the side that faces the turn
        if (dir_l != dir_r) begin
            if (r_x > 0) begin
                mix_rs = '0;
            end else begin
                mix_ls = '0;
            end
        end
    end

    // Update held state with idle timeout and obstacle stop
    always_comb begin
        if (r_cmd) begin
            n_idle        = '0;
            n_left_speed  = r_mix_ls;
            n_right_speed = r_mix_rs;
            n_left_dir    = r_mix_ldir;
            n_right_dir   = r_mix_rdir;
        end else begin
            n_idle        = (r_idle == IDLE_MAX) ? r_idle : r_idle + 1'b1;
            n_left_speed  = r_left_speed;
            n_right_speed = r_right_speed;
            n_left_dir    = r_left_dir;
            n_right_dir   = r_right_dir;
        end
        if (n_idle > i_timeout_ticks) begin
            n_left_speed  = '0;
            n_right_speed = '0;
        end
        if (i_obstacle_enable && (r_ant_l || r_ant_r)) begin
            if (!n_left_dir) begin
                n_left_speed = '0;
            end
            if (!n_right_dir) begin
                n_right_speed = '0;
            end
        end
    end

    // Capture the beat and run the datapath steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_command_valid;
            r_radius <= (i_radius_percent > RADIUS_MAX) ? RADIUS_MAX : i_radius_percent;
            r_angle  <= (i_angle_degrees >= ANGLE_W'(ANGLE_STEPS))
                        ? i_angle_degrees - ANGLE_W'(ANGLE_STEPS) : i_angle_degrees;
            r_ant_l  <= i_antenna_left;
            r_ant_r  <= i_antenna_right;
        end
        if (i_cmd.calc_x) begin
            r_x <= axis_val;
        end
        if (i_cmd.calc_y) begin
            r_y <= axis_val;
        end
        if (i_cmd.mix) begin
            r_mix_ls   <= mix_ls;
            r_mix_rs   <= mix_rs;
            r_mix_ldir <= dir_l;
            r_mix_rdir <= dir_r;
        end
    end

    // Hold drive state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_speed  <= '0;
            r_right_speed <= '0;
            r_left_dir    <= 1'b0;
            r_right_dir   <= 1'b0;
            r_idle        <= '0;
        end else if (i_cmd.commit) begin
            r_left_speed  <= n_left_speed;
            r_right_speed <= n_right_speed;
            r_left_dir    <= n_left_dir;
            r_right_dir   <= n_right_dir;
            r_idle        <= n_idle;
        end
    end

    assign o_left_speed_out  = r_left_speed;
    assign o_right_speed_out = r_right_speed;
    assign o_left_reverse    = r_left_dir;
    assign o_right_reverse   = r_right_dir;

endmodule

// ===== sv/polar_joystick_differential_drive.sv =====
// Joystick-to-differential-drive mixer. Each input beat is one control tick; when it
// carries a command, radius and angle are turned into x and y through a quarter-wave
// sine table and mixed into left and right duty values with direction bits, which are
// then held until the next command. A no-command timeout and the antenna obstacle stop
// can force held speeds to zero. After the capture at the accepting edge, the states
// S_COS, S_SIN, S_MIX and S_DONE form the x product, the y product, the mix and the
// commit in turn, and the commit waits while an earlier result is still held. One
// shared radius multiplier and one table read serve x and y in turn. The next beat is
// accepted in the cycle after the commit, also while the result still waits, so a new
// beat is taken only once the last one has been committed.
// Registers (APB, byte address): 0x0 timeout_ticks (reset 250), 0x4 obstacle_enable.
module polar_joystick_differential_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command_valid,
    input  logic [6:0]  i_radius_percent,
    input  logic [8:0]  i_angle_degrees,
    input  logic        i_antenna_left,
    input  logic        i_antenna_right,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_left_speed_out,
    output logic [7:0]  o_right_speed_out,
    output logic        o_left_reverse,
    output logic        o_right_reverse,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pjdd_pkg::*;

    logic [IDLE_W-1:0] r_timeout_ticks;
    logic              r_obstacle_enable;
    logic              reg_sel;
    t_dp_cmd           cmd;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks   <= IDLE_W'(250);
            r_obstacle_enable <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_TIMEOUT:  r_timeout_ticks   <= pwdata[IDLE_W-1:0];
                REG_OBSTACLE: r_obstacle_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        unique case (reg_sel)
            REG_TIMEOUT:  prdata = {{(32-IDLE_W){1'b0}}, r_timeout_ticks};
            REG_OBSTACLE: prdata = {31'b0, r_obstacle_enable};
            default:      prdata = '0;
        endcase
    end

    pjdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pjdd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_command_valid   (i_command_valid),
        .i_radius_percent  (i_radius_percent),
        .i_angle_degrees   (i_angle_degrees),
        .i_antenna_left    (i_antenna_left),
        .i_antenna_right   (i_antenna_right),
        .i_timeout_ticks   (r_timeout_ticks),
        .i_obstacle_enable (r_obstacle_enable),
        .o_left_speed_out  (o_left_speed_out),
        .o_right_speed_out (o_right_speed_out),
        .o_left_reverse    (o_left_reverse),
        .o_right_reverse   (o_right_reverse)
    );

endmodule
